### rtl/core/mcss_pkg.sv
// ----------------------------------------------------------------------------
// Markov chain step sampler package
// Shared constants, command codes and control structs of the sampler.
// ----------------------------------------------------------------------------
package mcss_pkg;

    // Default sizes of the chain and of the probability format.
    localparam int MAX_STATES_DEF     = 16;
    localparam int PROB_FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int CMD_W = 2;
    localparam int CNT_W = 32;

    // Number of states in use after reset, before any clamp to the table size.
    localparam int NUM_STATES_RST = 16;

    // Item commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_WR_ENTRY  = 2'd0,
        CMD_SET_STATE = 2'd1,
        CMD_STEP      = 2'd2
    } t_cmd;

    // Requests from the sequencer to the row scan unit.
    typedef struct packed {
        logic start;
        logic wr;
    } t_scan_ctl;

    // Status from the row scan unit back to the sequencer.
    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_res;

endpackage

### rtl/core/mcss_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mcss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/mcss_hist.sv
// ----------------------------------------------------------------------------
// Visit histogram
// Saturating visit counters in a RAM, updated by read, increment and write
// back. Valid bits make entries that were never written read as zero.
// ----------------------------------------------------------------------------
module mcss_hist #(
    parameter int MAX_STATES = mcss_pkg::MAX_STATES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_STATES)-1:0] i_idx,
    output logic                          o_count_vld,
    output logic [mcss_pkg::CNT_W-1:0]    o_count
);

    localparam int IDX_W = $clog2(MAX_STATES);
    localparam int CNT_W = mcss_pkg::CNT_W;

    logic [MAX_STATES-1:0] r_valid;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_idx;
    logic [CNT_W-1:0]      rdata;
    logic [CNT_W-1:0]      old_count;
    logic [CNT_W-1:0]      new_count;

    mcss_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_STATES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (r_pend),
        .i_waddr (r_idx),
        .i_wdata (new_count),
        .i_re    (i_rd_en),
        .i_raddr (i_idx),
        .o_rdata (rdata)
    );

    // Saturating increment of the count that came back from the RAM.
    always_comb begin
        old_count = r_valid[r_idx] ? rdata : '0;
        new_count = (old_count == '1) ? old_count : old_count + CNT_W'(1);
    end

    // Track the read in flight; the write back follows in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= i_rd_en;
            if (r_pend) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_idx <= i_idx;
        end
    end

    assign o_count_vld = r_pend;
    assign o_count     = new_count;

endmodule

### rtl/core/mcss_scan.sv
// ----------------------------------------------------------------------------
// Transition table and row scan
// Holds the transition table in a RAM and scans one row a column per cycle,
// accumulating the running sum until it reaches the random value or the last column in use.
// ----------------------------------------------------------------------------
module mcss_scan #(
    parameter int MAX_STATES     = mcss_pkg::MAX_STATES_DEF,
    parameter int PROB_FRAC_BITS = mcss_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcss_pkg::t_scan_ctl           i_ctl,
    input  logic [$clog2(MAX_STATES)-1:0] i_row,
    input  logic [$clog2(MAX_STATES)-1:0] i_col,
    input  logic [PROB_FRAC_BITS:0]       i_wdata,
    input  logic [PROB_FRAC_BITS-1:0]     i_rnd,
    input  logic [$clog2(MAX_STATES)-1:0] i_last,
    output mcss_pkg::t_scan_res           o_res,
    output logic [$clog2(MAX_STATES)-1:0] o_next
);

    localparam int IDX_W  = $clog2(MAX_STATES);
    localparam int PROB_W = PROB_FRAC_BITS + 1;
    localparam int DEPTH  = MAX_STATES * MAX_STATES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = PROB_W + IDX_W;

    logic                      r_busy;
    logic [IDX_W-1:0]          r_col;
    logic [IDX_W-1:0]          r_last;
    logic [ADDR_W-1:0]         r_addr;
    logic [SUM_W-1:0]          r_sum;
    logic [PROB_FRAC_BITS-1:0] r_rnd;

    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              re;
    logic [PROB_W-1:0] rdata;
    logic [SUM_W-1:0]  sum_new;
    logic              hit;
    logic              scan_end;

    // Row base and entry address; the row size is a constant.
    always_comb begin
        row_base = ADDR_W'(i_row) * ADDR_W'(MAX_STATES);
        waddr    = row_base + ADDR_W'(i_col);
    end

    // Running sum of the entry read for the current column.
    always_comb begin
        sum_new  = r_sum + SUM_W'(rdata);
        hit      = SUM_W'(r_rnd) <= sum_new;
        scan_end = r_busy && (hit || (r_col == r_last));
    end

    // The first read goes out with the start; each busy cycle but the last reads ahead.
    always_comb begin
        raddr = i_ctl.start ? row_base : r_addr + ADDR_W'(1);
        re    = i_ctl.start || (r_busy && !scan_end);
    end

    mcss_ram #(
        .WIDTH (PROB_W),
        .DEPTH (DEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr),
        .i_waddr (waddr),
        .i_wdata (i_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Scan control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
        end else if (scan_end) begin
            r_busy <= 1'b0;
        end
    end

    // Scan datapath.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_col  <= '0;
            r_addr <= row_base;
            r_sum  <= '0;
            r_rnd  <= i_rnd;
            r_last <= i_last;
        end else if (r_busy) begin
            r_col  <= r_col + IDX_W'(1);
            r_addr <= raddr;
            r_sum  <= sum_new;
        end
    end

    always_comb begin
        o_res.done = scan_end;
        o_res.hit  = hit;
        o_next     = hit ? r_col : r_last;
    end

endmodule

### rtl/core/markov_chain_step_sampler_top.sv
// ----------------------------------------------------------------------------
// Markov chain step sampler, top level
// A step item scans the current state's row in the table RAM at one entry per
// cycle, until the running sum reaches the random value or the last state in
// use; other items need no scan. One item is in work at a time, and a result
// waits while the output is stalled. Synchronous reset: state zero, counts
// zero, 16 states (MAX_STATES if that is fewer).
// ----------------------------------------------------------------------------
module markov_chain_step_sampler_top #(
    parameter int MAX_STATES     = mcss_pkg::MAX_STATES_DEF,
    parameter int PROB_FRAC_BITS = mcss_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration register: states in use.
    input  logic                             i_cfg_we,
    input  logic [$clog2(MAX_STATES+1)-1:0]  i_cfg_wdata,
    // Input items.
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mcss_pkg::CMD_W-1:0]       i_cmd,
    input  logic [$clog2(MAX_STATES)-1:0]    i_row_index,
    input  logic [$clog2(MAX_STATES)-1:0]    i_col_index,
    input  logic [PROB_FRAC_BITS:0]          i_prob_value,
    input  logic [$clog2(MAX_STATES)-1:0]    i_start_state,
    input  logic [PROB_FRAC_BITS-1:0]        i_rand_value,
    // Result items.
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [$clog2(MAX_STATES)-1:0]    o_visited_state,
    output logic [mcss_pkg::CNT_W-1:0]       o_visit_count,
    output logic [$clog2(MAX_STATES)-1:0]    o_next_state,
    output logic                             o_no_match
);

    localparam int IDX_W   = $clog2(MAX_STATES);
    localparam int NUM_W   = $clog2(MAX_STATES + 1);
    localparam int CNT_W   = mcss_pkg::CNT_W;
    localparam int NUM_RST = (MAX_STATES < mcss_pkg::NUM_STATES_RST) ?
                             MAX_STATES : mcss_pkg::NUM_STATES_RST;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_cur;
    logic [NUM_W-1:0] r_num;
    logic             r_out_vld;

    logic [IDX_W-1:0] r_res_visited;
    logic [CNT_W-1:0] r_res_count;
    logic [IDX_W-1:0] r_res_next;
    logic             r_res_miss;
    logic [IDX_W-1:0] r_out_visited;
    logic [CNT_W-1:0] r_out_count;
    logic [IDX_W-1:0] r_out_next;
    logic             r_out_miss;

    mcss_pkg::t_cmd      cmd;
    mcss_pkg::t_scan_ctl scan_ctl;
    mcss_pkg::t_scan_res scan_res;
    logic [NUM_W-1:0]    n_use;
    logic [IDX_W-1:0]    last;
    logic [IDX_W-1:0]    cur_eff;
    logic [IDX_W-1:0]    start_sat;
    logic [IDX_W-1:0]    scan_row;
    logic [IDX_W-1:0]    scan_next;
    logic                tbl_ok;
    logic                acc;
    logic                out_load;
    logic                cnt_vld;
    logic [CNT_W-1:0]    cnt_new;

    // States in use, clamped to the table size, and saturated state indexes.
    always_comb begin
        if (r_num == '0) begin
            n_use = NUM_W'(1);
        end else if (r_num > NUM_W'(MAX_STATES)) begin
            n_use = NUM_W'(MAX_STATES);
        end else begin
            n_use = r_num;
        end
        last      = IDX_W'(n_use - NUM_W'(1));
        cur_eff   = (NUM_W'(r_cur) >= n_use) ? last : r_cur;
        start_sat = (NUM_W'(i_start_state) >= n_use) ? last : i_start_state;
        tbl_ok    = (NUM_W'(i_row_index) < NUM_W'(MAX_STATES)) &&
                    (NUM_W'(i_col_index) < NUM_W'(MAX_STATES));
    end

    // Item handshake and requests to the scan unit and the histogram.
    always_comb begin
        cmd            = mcss_pkg::t_cmd'(i_cmd);
        o_ready        = (r_state == S_IDLE);
        acc            = i_valid && o_ready;
        scan_ctl.wr    = acc && (cmd == mcss_pkg::CMD_WR_ENTRY) && tbl_ok;
        scan_ctl.start = acc && (cmd == mcss_pkg::CMD_STEP);
        scan_row       = (cmd == mcss_pkg::CMD_STEP) ? cur_eff : i_row_index;
        out_load       = (r_state == S_DONE) && (!r_out_vld || i_ready);
    end

    mcss_scan #(
        .MAX_STATES     (MAX_STATES),
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_row   (scan_row),
        .i_col   (i_col_index),
        .i_wdata (i_prob_value),
        .i_rnd   (i_rand_value),
        .i_last  (last),
        .o_res   (scan_res),
        .o_next  (scan_next)
    );

    mcss_hist #(
        .MAX_STATES (MAX_STATES)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (scan_ctl.start),
        .i_idx       (cur_eff),
        .o_count_vld (cnt_vld),
        .o_count     (cnt_new)
    );

    // Sequencer: accept, scan for a step, then hand over to the output.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = (cmd == mcss_pkg::CMD_STEP) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_num     <= NUM_W'(NUM_RST);
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_num <= i_cfg_wdata;
            end
            if (acc && (cmd == mcss_pkg::CMD_SET_STATE)) begin
                r_cur <= start_sat;
            end else if (scan_res.done) begin
                r_cur <= scan_next;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result of the item in work, then the output register.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res_miss <= 1'b0;
            if (cmd == mcss_pkg::CMD_STEP) begin
                r_res_visited <= cur_eff;
            end else begin
                r_res_visited <= '0;
                r_res_count   <= '0;
                r_res_next    <= (cmd == mcss_pkg::CMD_SET_STATE) ? start_sat : r_cur;
            end
        end
        if (cnt_vld) begin
            r_res_count <= cnt_new;
        end
        if (scan_res.done) begin
            r_res_next <= scan_next;
            r_res_miss <= !scan_res.hit;
        end
        if (out_load) begin
            r_out_visited <= r_res_visited;
            r_out_count   <= r_res_count;
            r_out_next    <= r_res_next;
            r_out_miss    <= r_res_miss;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_visited_state = r_out_visited;
    assign o_visit_count   = r_out_count;
    assign o_next_state    = r_out_next;
    assign o_no_match      = r_out_miss;

endmodule
